// ===== hw/rtl/rse_pkg.sv =====
package rse_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned QUEUE_DEPTH = 2;  // power of two, pointers wrap

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_NOP
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECODE,
    BK_FETCH,
    BK_DIV,
    BK_WB
  } back_state_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
    logic                     ends_expression;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [1:0]               status;
    logic                     is_final;
  } out_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  value;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rse_front.sv =====
module rse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rse_pkg::in_item_t in_item_i,
  output logic              q_push_o,
  output rse_pkg::cmd_t     q_cmd_o,
  input  logic              q_full_i
);
  import rse_pkg::*;

  logic  fr_valid_q, fr_valid_d;
  cmd_t  fr_cmd_q;
  cmd_t  cls_cmd;
  logic  accept;

  always_comb begin
    cls_cmd.value = in_item_i.operand_value;
    cls_cmd.last  = in_item_i.ends_expression;
    case (in_item_i.opcode)
      OP_PUSH: cls_cmd.kind = K_PUSH;
      OP_ADD:  cls_cmd.kind = K_ADD;
      OP_SUB:  cls_cmd.kind = K_SUB;
      OP_MUL:  cls_cmd.kind = K_MUL;
      OP_DIV:  cls_cmd.kind = K_DIV;
      default: cls_cmd.kind = K_NOP;
    endcase
  end

  assign in_stall_o = fr_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = fr_valid_q && !q_full_i;
  assign q_cmd_o    = fr_cmd_q;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (q_push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_cmd_q <= cls_cmd;
    end
  end

endmodule

// ===== hw/rtl/rse_fifo.sv =====
module rse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rse_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rse_pkg::cmd_t cmd_o
);
  import rse_pkg::*;

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/rse_div.sv =====
module rse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rse_pkg::div_req_t req_i,
  output rse_pkg::div_rsp_t rsp_o
);
  import rse_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_W);
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_W - 1);

  logic              busy_q, done_q, neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic [DATA_W:0]   shifted, diff;
  logic [DATA_W-1:0] mag_a, mag_b;

  assign mag_a   = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
  assign mag_b   = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], !diff[DATA_W]};
    end
  end

endmodule

// ===== hw/rtl/rse_back.sv =====
module rse_back #(
  parameter int unsigned StackDepth = rse_pkg::STACK_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  rse_pkg::cmd_t      q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rse_pkg::out_item_t out_item_o,
  output rse_pkg::div_req_t  div_req_o,
  input  rse_pkg::div_rsp_t  div_rsp_i
);
  import rse_pkg::*;

  localparam int unsigned IdxW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned SpW  = $clog2(StackDepth + 1);
  localparam logic [SpW-1:0] SpFull = SpW'(StackDepth);
  localparam logic [SpW-1:0] SpTwo  = SpW'(2);
  localparam logic [SpW-1:0] SpOne  = SpW'(1);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic [DATA_W-1:0] top_q, top_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  // entries below the top; the top itself lives in top_q
  logic [DATA_W-1:0] stack_mem [StackDepth];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;

  logic                  slot_free, is_arith, div_by_zero;
  logic [2*DATA_W-1:0]   prod;
  logic [SpW+DEPTH_W-1:0] sp_ext;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign is_arith    = cmd_q.kind inside {K_ADD, K_SUB, K_MUL, K_DIV};
  assign div_by_zero = (cmd_q.kind == K_DIV) && (top_q == '0);
  assign prod        = rdata_q * top_q;
  assign sp_ext      = (SpW + DEPTH_W)'(sp_q);
  assign mem_waddr   = IdxW'(sp_q - SpOne);
  assign mem_raddr   = IdxW'(sp_q - SpTwo);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) state_d = BK_DECODE;
      end
      BK_DECODE: begin
        if (is_arith && (sp_q >= SpTwo) && !div_by_zero) begin
          state_d = BK_FETCH;
        end else begin
          state_d = BK_WB;
        end
      end
      BK_FETCH: begin
        state_d = (cmd_q.kind == K_DIV) ? BK_DIV : BK_WB;
      end
      BK_DIV: begin
        if (div_rsp_i.done) state_d = BK_WB;
      end
      BK_WB: begin
        if (slot_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o            = 1'b0;
    cmd_d              = cmd_q;
    sp_d               = sp_q;
    top_d              = top_q;
    status_d           = status_q;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = rdata_q;
    div_req_o.divisor  = top_q;
    out_valid_d        = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;
    out_item_d         = out_item_q;
    case (state_q)
      BK_IDLE: begin
        q_pop_o  = q_valid_i;
        cmd_d    = q_cmd_i;
        status_d = ST_OK;
      end
      BK_DECODE: begin
        case (cmd_q.kind)
          K_PUSH: begin
            if (sp_q == SpFull) begin
              status_d = ST_OVER;
            end else begin
              mem_we = (sp_q != '0);
              top_d  = cmd_q.value;
              sp_d   = sp_q + SpOne;
            end
          end
          K_ADD, K_SUB, K_MUL, K_DIV: begin
            if (sp_q < SpTwo) begin
              status_d = ST_UNDER;
            end else if (div_by_zero) begin
              status_d = ST_DIVZ;
            end else begin
              mem_re = 1'b1;
            end
          end
          default: ;
        endcase
      end
      BK_FETCH: begin
        case (cmd_q.kind)
          K_ADD: begin
            top_d = rdata_q + top_q;
            sp_d  = sp_q - SpOne;
          end
          K_SUB: begin
            top_d = rdata_q - top_q;
            sp_d  = sp_q - SpOne;
          end
          K_MUL: begin
            top_d = prod[DATA_W-1:0];
            sp_d  = sp_q - SpOne;
          end
          K_DIV: div_req_o.start = 1'b1;
          default: ;
        endcase
      end
      BK_DIV: begin
        if (div_rsp_i.done) begin
          top_d = div_rsp_i.quotient;
          sp_d  = sp_q - SpOne;
        end
      end
      BK_WB: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_item_d.top_value   = (sp_q != '0) ? top_q : '0;
          out_item_d.stack_depth = sp_ext[DEPTH_W-1:0];
          out_item_d.status      = status_q;
          out_item_d.is_final    = cmd_q.last;
          // empty the stack once the closing token has been reported
          if (cmd_q.last) sp_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    top_q      <= top_d;
    status_q   <= status_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= top_q;
    end
    if (mem_re) begin
      rdata_q <= stack_mem[mem_raddr];
    end
  end

endmodule

// ===== hw/rtl/rpn_stack_evaluator_core.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_item_i  (opcode, operand_value, end)
// out     | output    | out_valid_o / out_stall_i  | out_item_o (top, depth, status, final)
//
// Push, unknown opcodes and rejected tokens pass IDLE, DECODE and WB in the execute
// unit; add/sub/mul also pass FETCH, divide passes FETCH and DIV for the radix-2
// divider (one quotient bit per cycle). Reset clears the stack pointer and the
// handshake state; stack entries are not cleared. Input transfers continue into a two-entry
// queue while the output register is stalled; the execute unit holds until it drains.
module rpn_stack_evaluator_core #(
  parameter int unsigned StackDepth = rse_pkg::STACK_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rse_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rse_pkg::out_item_t out_item_o
);
  import rse_pkg::*;

  logic     q_push, q_full, q_pop, q_valid;
  cmd_t     q_in_cmd, q_out_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  rse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in_cmd),
    .q_full_i   (q_full)
  );

  rse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_out_cmd)
  );

  rse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rse_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_out_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_div_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !div_req.start)
    else $error("divider restarted while finishing");

  a_over_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_OVER)) |->
      (out_item_o.stack_depth == DEPTH_W'(StackDepth)))
    else $error("overflow reported on a stack that is not full");

  a_under_shallow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_UNDER)) |->
      (out_item_o.stack_depth < DEPTH_W'(2)))
    else $error("underflow reported with two or more entries");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rse_pkg::*;

  localparam int          IDLE_PCT     = 24;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          TOKEN_TARGET = 1550;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          QUIET_FROM   = 4000;
  localparam int          QUIET_TO     = 9000;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [2:0]  OP_UNUSED_MID = 3'd6;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [31:0] INT_MIN      = 32'h8000_0000;
  localparam logic [31:0] INT_MAX      = 32'h7fff_ffff;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  rpn_stack_evaluator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int cycle_cnt = 0;
  logic quiet_window;
  assign quiet_window = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  // Token stream and generator-side depth estimate
  in_item_t    pending_tokens[$];
  int unsigned gen_depth;
  int unsigned planned_tokens;

  // Shadow evaluator state
  logic [31:0] shadow_stack [STACK_DEPTH];
  int unsigned shadow_fill;
  out_item_t   expected_results[$];

  int unsigned tokens_evaluated, exprs_closed, peak_fill;
  int unsigned n_underflow, n_overflow, n_divzero, n_unknown;
  int unsigned mismatch_cnt;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d tokens pending and %0d results outstanding",
               CYCLE_LIMIT, pending_tokens.size(), expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] trunc_divide(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n, mag_d, quo;
    mag_n = num[31] ? (32'd0 - num) : num;
    mag_d = den[31] ? (32'd0 - den) : den;
    quo   = mag_n / mag_d;
    return (num[31] != den[31]) ? (32'd0 - quo) : quo;
  endfunction

  function automatic void evaluate_token(in_item_t tok);
    out_item_t   res;
    logic [31:0] lhs, rhs, val;
    res          = '0;
    res.status   = ST_OK;
    res.is_final = tok.ends_expression;
    val          = '0;
    case (tok.opcode)
      OP_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          shadow_stack[shadow_fill] = tok.operand_value;
          shadow_fill++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_fill < 2) begin
          res.status = ST_UNDER;
        end else begin
          rhs = shadow_stack[shadow_fill-1];
          lhs = shadow_stack[shadow_fill-2];
          case (tok.opcode)
            OP_ADD: val = lhs + rhs;
            OP_SUB: val = lhs - rhs;
            OP_MUL: val = lhs * rhs;
            default: begin
              if (rhs == 32'd0) res.status = ST_DIVZ;
              else val = trunc_divide(lhs, rhs);
            end
          endcase
          if (res.status == ST_OK) begin
            shadow_stack[shadow_fill-2] = val;
            shadow_fill--;
          end
        end
      end
      default: n_unknown++;
    endcase
    if (shadow_fill > 0) res.top_value = shadow_stack[shadow_fill-1];
    res.stack_depth = 7'(shadow_fill);
    case (res.status)
      ST_UNDER: n_underflow++;
      ST_OVER:  n_overflow++;
      ST_DIVZ:  n_divzero++;
      default: ;
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    tokens_evaluated++;
    // Clear after reporting, even when the token raised an error
    if (tok.ends_expression) begin
      shadow_fill = 0;
      exprs_closed++;
    end
    expected_results.push_back(res);
  endfunction

  function automatic void queue_token(logic [2:0] op, logic [31:0] val, logic fin);
    in_item_t tok;
    tok.opcode          = op;
    tok.operand_value   = val;
    tok.ends_expression = fin;
    pending_tokens.push_back(tok);
    case (op)
      OP_PUSH: if (gen_depth < STACK_DEPTH) gen_depth++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (gen_depth >= 2) gen_depth--;
      default: ;
    endcase
    planned_tokens++;
    if (fin) gen_depth = 0;
  endfunction

  function automatic void close_expression();
    pending_tokens[pending_tokens.size()-1].ends_expression = 1'b1;
    gen_depth = 0;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return 32'd0;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($signed($urandom_range(200, 0)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_operator();
    return 3'($urandom_range(OP_DIV, OP_ADD));
  endfunction

  function automatic void build_directed();
    queue_token(OP_ADD,  32'd0,          1'b0);  // underflow on empty stack
    queue_token(OP_PUSH, INT_MAX,        1'b0);
    queue_token(OP_MUL,  32'd0,          1'b0);  // underflow with one entry
    queue_token(OP_PUSH, 32'd1,          1'b0);
    queue_token(OP_ADD,  32'hdead_beef,  1'b0);  // wraps to most negative
    queue_token(OP_PUSH, 32'd1,          1'b0);
    queue_token(OP_SUB,  32'd0,          1'b0);  // wraps back to most positive
    queue_token(OP_PUSH, 32'hffff_ffff,  1'b0);
    queue_token(OP_MUL,  32'd0,          1'b0);
    queue_token(OP_PUSH, 32'd0,          1'b0);
    queue_token(OP_DIV,  32'd0,          1'b0);  // divide by zero keeps stack
    queue_token(OP_UNUSED_HI, 32'hffff_ffff, 1'b0);
    queue_token(OP_UNUSED_LO, 32'h5555_5555, 1'b1);  // ignored token closes expression
    queue_token(OP_PUSH, INT_MIN,        1'b0);
    queue_token(OP_PUSH, 32'hffff_ffff,  1'b0);
    queue_token(OP_DIV,  32'd0,          1'b0);  // most negative over minus one
    queue_token(OP_PUSH, 32'hffff_fff9,  1'b0);
    queue_token(OP_PUSH, 32'd2,          1'b0);
    queue_token(OP_DIV,  32'd0,          1'b0);  // truncates toward zero
    queue_token(OP_SUB,  32'd0,          1'b0);
    queue_token(OP_PUSH, 32'd0,          1'b0);
    queue_token(OP_DIV,  32'd0,          1'b1);  // error on the final token
    queue_token(OP_UNUSED_MID, 32'd0,    1'b0);
    queue_token(OP_PUSH, 32'haaaa_aaaa,  1'b1);
  endfunction

  function automatic void build_random();
    int unsigned pushes_left, roll;
    while (planned_tokens < TOKEN_TARGET) begin
      roll = $urandom_range(99, 0);
      if (roll < 63) begin
        // well-formed expression with random content
        pushes_left = $urandom_range(10, 1);
        while (pushes_left > 0 || gen_depth > 1) begin
          if (pushes_left > 0 && (gen_depth < 2 || $urandom_range(1, 0) == 1)) begin
            queue_token(OP_PUSH, pick_value(), 1'b0);
            pushes_left--;
          end else begin
            queue_token(pick_operator(), $urandom, 1'b0);
          end
        end
        close_expression();
      end else if (roll < 66) begin
        // push the stack near or past its ceiling
        repeat ($urandom_range(70, 62)) queue_token(OP_PUSH, pick_value(), 1'b0);
        repeat ($urandom_range(4, 1)) queue_token(pick_operator(), $urandom, 1'b0);
        close_expression();
      end else begin
        repeat ($urandom_range(6, 1))
          queue_token(3'($urandom_range(OP_UNUSED_HI, OP_PUSH)), $urandom,
                      $urandom_range(3, 0) == 0);
      end
    end
  endfunction

  // Driver: evaluate on transfer, then present the next token unless idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) evaluate_token(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_tokens.size() != 0 && (quiet_window || $urandom_range(99, 0) >= IDLE_PCT)) begin
          in_item_i  <= pending_tokens.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_window && ($urandom_range(99, 0) < IDLE_PCT);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] unexpected result: top %0d depth %0d status %0d final %0b", $realtime,
                   out_item_o.top_value, out_item_o.stack_depth, out_item_o.status,
                   out_item_o.is_final);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.top_value !== want.top_value || out_item_o.stack_depth !== want.stack_depth ||
            out_item_o.status !== want.status || out_item_o.is_final !== want.is_final) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] mismatch: top %0d/%0d depth %0d/%0d status %0d/%0d final %0b/%0b",
                     $realtime, want.top_value, out_item_o.top_value, want.stack_depth,
                     out_item_o.stack_depth, want.status, out_item_o.status,
                     want.is_final, out_item_o.is_final);
        end
      end
    end
  end

  initial begin
    gen_depth        = 0;
    planned_tokens   = 0;
    shadow_fill      = 0;
    tokens_evaluated = 0;
    exprs_closed     = 0;
    peak_fill        = 0;
    n_underflow      = 0;
    n_overflow       = 0;
    n_divzero        = 0;
    n_unknown        = 0;
    mismatch_cnt     = 0;
    build_directed();
    build_random();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_tokens.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Evaluated %0d tokens (%0d unknown opcodes) over %0d closed expressions, peak depth %0d",
             tokens_evaluated, n_unknown, exprs_closed, peak_fill);
    $display("Error paths hit: %0d underflow, %0d overflow, %0d divide by zero; %0d mismatches",
             n_underflow, n_overflow, n_divzero, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rse_pkg.sv
hw/rtl/rse_front.sv
hw/rtl/rse_fifo.sv
hw/rtl/rse_div.sv
hw/rtl/rse_back.sv
hw/rtl/rpn_stack_evaluator_core.sv
bench/tb_top.sv
